/* rtl/ssc_pkg.sv */
`default_nettype none
package ssc_pkg;

  localparam int unsigned CLS_W      = 8;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned TAGS_W     = 64;
  localparam int unsigned CIU_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_SLOT      = 1'b0,
    CFG_CLASSES_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_OPEN,
    ST_SCAN,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [CLS_W-1:0] class_found;
    logic             fell_back_open;
  } ssc_result_t;

endpackage
`default_nettype wire

/* rtl/ssc_if.sv */
`default_nettype none
interface ssc_in_if;
  import ssc_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [SLOT_W-1:0] entry_slot;
  logic [TAGS_W-1:0] tag_bits;
  modport source (output valid, op, entry_slot, tag_bits, input ready);
  modport sink   (input valid, op, entry_slot, tag_bits, output ready);
endinterface

interface ssc_out_if;
  import ssc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CLS_W-1:0] class_found;
  logic             fell_back_open;
  modport source (output valid, class_found, fell_back_open, input ready);
  modport sink   (input valid, class_found, fell_back_open, output ready);
endinterface

interface ssc_cfg_if;
  import ssc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/ssc_mem.sv */
`default_nettype none
module ssc_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 71
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/ssc_unit.sv */
`default_nettype none
module ssc_unit #(
  parameter int unsigned TAG_COUNT = 64,
  parameter int unsigned SIZE_W    = 7
) (
  input  wire logic [TAG_COUNT-1:0] query_i,
  input  wire logic [TAG_COUNT-1:0] entry_mask_i,
  input  wire logic [SIZE_W-1:0]    entry_size_i,
  input  wire logic [SIZE_W-1:0]    best_len_i,
  input  wire logic [7:0]           chunk_i,
  output logic                      take_o,
  output logic [3:0]                chunk_cnt_o
);

  // entry wins only if it covers the whole query and is strictly smaller
  assign take_o = ((query_i & ~entry_mask_i) == '0) && (entry_size_i < best_len_i);

  always_comb begin
    chunk_cnt_o = '0;
    for (int i = 0; i < 8; i++) begin
      chunk_cnt_o = chunk_cnt_o + 4'(chunk_i[i]);
    end
  end

endmodule
`default_nettype wire

/* rtl/ssc_seq.sv */
`default_nettype none
module ssc_seq #(
  parameter int unsigned MAX_CLASSES = 256,
  parameter int unsigned TAG_COUNT   = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  ssc_in_if.sink                           in_i,
  input  wire logic [ssc_pkg::SLOT_W-1:0]  open_slot_i,
  input  wire logic [ssc_pkg::CIU_W-1:0]   classes_in_use_i,
  output logic                             res_valid_o,
  output ssc_pkg::ssc_result_t             res_o,
  input  wire logic                        res_ready_i
);
  import ssc_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_CLASSES);
  localparam int unsigned SIZE_W  = $clog2(TAG_COUNT + 1);
  localparam int unsigned DW      = SIZE_W + TAG_COUNT;
  localparam int unsigned LIM_MAX = (MAX_CLASSES < 256) ? MAX_CLASSES : 256;
  localparam int unsigned LIM_W   = $clog2(LIM_MAX + 1);
  localparam int unsigned NCH     = (TAG_COUNT + 7) / 8;
  localparam int unsigned POP_W   = NCH * 8;

  seq_state_e           state_q, state_d;
  logic [TAG_COUNT-1:0] mask_q, mask_d;
  logic [POP_W-1:0]     pop_q, pop_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [CLS_W-1:0]     best_q, best_d;
  logic [SIZE_W-1:0]    best_len_q, best_len_d;
  logic [LIM_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 chk_v_q, chk_v_d;
  logic [CLS_W-1:0]     chk_idx_q, chk_idx_d;

  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [DW-1:0]        mem_rdata;
  logic [TAG_COUNT-1:0] ent_mask;
  logic [SIZE_W-1:0]    ent_size;
  logic                 take;
  logic [3:0]           chunk_cnt;
  logic [LIM_W-1:0]     limit;
  logic                 open_in_table;
  logic                 slot_in_table;

  assign limit = (32'(classes_in_use_i) > LIM_MAX) ? LIM_W'(LIM_MAX)
                                                    : LIM_W'(classes_in_use_i);
  assign open_in_table = 32'(open_slot_i) < MAX_CLASSES;
  assign slot_in_table = 32'(slot_q) < MAX_CLASSES;

  assign ent_mask = mem_rdata[TAG_COUNT-1:0];
  assign ent_size = mem_rdata[DW-1:TAG_COUNT];

  ssc_mem #(
    .DEPTH (MAX_CLASSES),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (IDX_W'(slot_q)),
    .wdata_i ({size_q, mask_q}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ssc_unit #(
    .TAG_COUNT (TAG_COUNT),
    .SIZE_W    (SIZE_W)
  ) u_unit (
    .query_i      (mask_q),
    .entry_mask_i (ent_mask),
    .entry_size_i (ent_size),
    .best_len_i   (best_len_q),
    .chunk_i      (pop_q[7:0]),
    .take_o       (take),
    .chunk_cnt_o  (chunk_cnt)
  );

  assign in_i.ready           = (state_q == ST_IDLE);
  assign res_valid_o          = (state_q == ST_DONE);
  assign res_o.class_found    = best_q;
  assign res_o.fell_back_open = (best_q == open_slot_i);

  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    pop_d      = pop_q;
    size_d     = size_q;
    slot_d     = slot_q;
    best_d     = best_q;
    best_len_d = best_len_q;
    rd_idx_d   = rd_idx_q;
    chk_v_d    = chk_v_q;
    chk_idx_d  = chk_idx_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mask_d = in_i.tag_bits[TAG_COUNT-1:0];
          pop_d  = POP_W'(in_i.tag_bits[TAG_COUNT-1:0]);
          size_d = '0;
          slot_d = in_i.entry_slot;
          if (in_i.op == OP_WRITE) begin
            state_d = ST_POP;
          end else begin
            best_d     = open_slot_i;
            best_len_d = '0;
            rd_idx_d   = '0;
            chk_v_d    = 1'b0;
            if (open_in_table) begin
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(open_slot_i);
              state_d   = ST_OPEN;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_POP: begin
        // count one byte per cycle, store once no set bits remain
        if (pop_q == '0) begin
          mem_we  = slot_in_table;
          state_d = ST_IDLE;
        end else begin
          size_d = size_q + SIZE_W'(chunk_cnt);
          pop_d  = pop_q >> 8;
        end
      end
      ST_OPEN: begin
        best_len_d = ent_size;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        // check the entry read last cycle while issuing the next read
        if (chk_v_q && take) begin
          best_d     = chk_idx_q;
          best_len_d = ent_size;
        end
        if (rd_idx_q < limit) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(rd_idx_q);
          chk_idx_d = CLS_W'(rd_idx_q);
          chk_v_d   = 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_v_q <= chk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q     <= mask_d;
    pop_q      <= pop_d;
    size_q     <= size_d;
    slot_q     <= slot_d;
    best_q     <= best_d;
    best_len_q <= best_len_d;
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
  end

endmodule
`default_nettype wire

/* rtl/smallest_superset_class_lookup_core.sv */
// Smallest superset class lookup.
// in_i carries items: op selects a class write (entry_slot, tag_bits) or a
// query (tag_bits). A write produces no result; a query produces one item on
// out_o naming the first, smallest stored class that covers the query and is
// smaller than the open class's entry, or the open class with fell_back_open
// set. cfg_i writes open_class_slot (index 0) and classes_in_use (index 1);
// it is always ready. A write is accepted, then its tag_bits are counted
// byte by byte up to the highest nonzero byte before it is stored. A query
// reads the open class's entry, if it lies in the table, then entries 0 to
// N-1, N = min(classes_in_use, MAX_CLASSES, 256): the table has one read
// port and the comparator checks one entry per cycle. in_i is ready only
// while no item is in work.
// Reset clears the configuration registers and the sequencer; the class
// table is not cleared and must be written before it is read.
// A finished result sits in an output register; while it is stalled the
// next item is still accepted, and a following query holds its own result
// until the output register frees up.
`default_nettype none
module smallest_superset_class_lookup_core #(
  parameter int unsigned MAX_CLASSES = 256,
  parameter int unsigned TAG_COUNT   = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssc_in_if.sink    in_i,
  ssc_out_if.source out_o,
  ssc_cfg_if.sink   cfg_i
);
  import ssc_pkg::*;

  logic [SLOT_W-1:0] open_slot_q, open_slot_d;
  logic [CIU_W-1:0]  classes_q, classes_d;
  logic              out_valid_q, out_valid_d;
  ssc_result_t       out_res_q, out_res_d;
  logic              res_valid;
  logic              res_ready;
  ssc_result_t       res;

  ssc_seq #(
    .MAX_CLASSES (MAX_CLASSES),
    .TAG_COUNT   (TAG_COUNT)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_i),
    .open_slot_i      (open_slot_q),
    .classes_in_use_i (classes_q),
    .res_valid_o      (res_valid),
    .res_o            (res),
    .res_ready_i      (res_ready)
  );

  assign cfg_i.ready = 1'b1;

  always_comb begin
    open_slot_d = open_slot_q;
    classes_d   = classes_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_OPEN_SLOT:      open_slot_d = cfg_i.data[SLOT_W-1:0];
        CFG_CLASSES_IN_USE: classes_d   = cfg_i.data[CIU_W-1:0];
        default:            open_slot_d = open_slot_q;
      endcase
    end
  end

  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.class_found    = out_res_q.class_found;
  assign out_o.fell_back_open = out_res_q.fell_back_open;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_slot_q <= '0;
      classes_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      open_slot_q <= open_slot_d;
      classes_q   <= classes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

endmodule
`default_nettype wire
